@@ sv/pmj_pkg.sv @@
// shared types and constants for the polyline miter join block
// command and status structs between controller and datapath, fsm states, unit widths
// no dependencies
package pmj_pkg;

  localparam int SQ_IN_W = 50;  // radicand: squared length in q16
  localparam int ROOT_W  = 25;  // segment length in q8
  localparam int NUM_W   = 60;  // divider numerator
  localparam int DEN_W   = 44;  // divider denominator
  localparam int CRD_W   = 24;  // q8 vertex coordinate

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK,
    S_SQ1, S_SQ2, S_SQ3, S_SQB_GO, S_SQB_W,
    S_PERP_M, S_PERP_D, S_PERP_W,
    S_CR1, S_CR2, S_CR3, S_CR4, S_CR5,
    S_SA, S_SQA_GO, S_SQA_W,
    S_MI1, S_MI2, S_MI3, S_MI4, S_MI5, S_MI6, S_MI_D, S_MI_W,
    S_EM_OM, S_EM_OP, S_EM_NM, S_EM_NP, S_UPD
  } state_t;

  typedef enum logic [3:0] {
    MS_BB_X, MS_BB_Y, MS_AA_X, MS_AA_Y, MS_H_B, MS_AX_BY, MS_AY_BX,
    MS_LA_B, MS_A_LB, MS_H_DHI, MS_H_DLO
  } mul_sel_t;

  typedef enum logic [2:0] {AC_HOLD, AC_LOAD, AC_ADD, AC_SUB, AC_HI} acc_op_t;

  typedef enum logic {DS_PROD, DS_ACC} div_src_t;

  typedef enum logic [2:0] {
    SV_NONE, SV_LB, SV_LA, SV_OFF, SV_MIT, SV_CROSS, SV_FIRST, SV_COMMIT
  } save_t;

  typedef enum logic [2:0] {EM_NONE, EM_OLD_M, EM_OLD_P, EM_NEW_M, EM_NEW_P} emit_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     sq_go;
    logic     div_go;
    div_src_t div_src;
    save_t    save;
    logic     axis;     // 0 works on x, 1 on y
    emit_t    emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic dup;
    logic full;
    logic cross_zero;
    logic sq_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

@@ sv/polyline_miter_join.sv @@
// Thick polyline tessellator with miter joins. Each accepted point yields up to four
// triangle-strip vertex writes (slot, q8 x, q8 y), the last one flagged by out_tlast.
// One point is handled at a time. The first point of a line only writes vertices, a
// second point adds a square root and the perpendicular divisions, a later point adds a
// cross product and, unless the segments are colinear, a square root and miter divisions;
// a repeated or dropped point is only checked. Output stalls hold the point in work. The
// iterative square root (25 steps) and divider (25 steps plus setup) are each a single
// shared unit, used up to twice and four times per point. Thickness is written through
// cfg_wr_en/cfg_wr_data; the user must do so only while no point is in work, which the
// block itself does not enforce. A repeated point or a point beyond MAX_POINTS in a line
// produces no transaction. Depends on pmj_pkg, pmj_ctrl, pmj_dp.
module polyline_miter_join import pmj_pkg::*; #(
  parameter int MAX_POINTS = 4096   // points per line, 2 to 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // thickness register, sixteenths of a pixel
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  // point input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // point_x [15:0], point_y [31:16]
  input  logic        in_tuser,    // new_line
  // vertex output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // vertex_index [12:0], vertex_x [36:13], vertex_y [60:37]
  output logic        out_tlast    // last vertex of this point
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_take;

  // a point transaction completes here
  assign in_take = in_tvalid && in_tready;

  pmj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pmj_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_take     (in_take),
    .in_x        ($signed(in_tdata[15:0])),
    .in_y        ($signed(in_tdata[31:16])),
    .in_new      (in_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

@@ sv/pmj_sqrt.sv @@
// iterative integer square root, one result bit per cycle
// depends on pmj_pkg
module pmj_sqrt import pmj_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [SQ_IN_W-1:0] din,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic               run_r;
  logic [4:0]         cnt_r;
  logic [SQ_IN_W-1:0] v_r, res_r, bit_r;
  logic [SQ_IN_W-1:0] trial;

  assign trial = res_r + bit_r;
  assign done  = run_r && (cnt_r == '0);
  assign root  = res_r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (go) begin
      run_r <= 1'b1;
      cnt_r <= 5'(ROOT_W);
    end else if (run_r) begin
      if (cnt_r == '0) run_r <= 1'b0;
      else             cnt_r <= cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      v_r   <= din;
      res_r <= '0;
      bit_r <= SQ_IN_W'(1) << (2 * (ROOT_W - 1));
    end else if (run_r && cnt_r != '0) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

@@ sv/pmj_div.sv @@
// iterative signed divider, rounds to nearest with ties away from zero,
// saturates the quotient to 24 bits; depends on pmj_pkg
module pmj_div import pmj_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [CRD_W-1:0] quo
);

  localparam int RW = DEN_W + CRD_W;  // room for den shifted by 24

  logic             run_r, prep_r, neg_r;
  logic [4:0]       cnt_r;
  logic [NUM_W-1:0] n_r;
  logic [DEN_W-1:0] d_r;
  logic [RW-1:0]    rem_r, dsh_r;
  logic [CRD_W:0]   q_r;
  logic             sat;

  assign done = run_r && (cnt_r == '0);
  assign sat  = q_r[CRD_W] | q_r[CRD_W-1];

  always_comb begin
    priority if (neg_r && sat) quo = {1'b1, {(CRD_W-1){1'b0}}};
    else if (sat)              quo = {1'b0, {(CRD_W-1){1'b1}}};
    else if (neg_r)            quo = -$signed(q_r[CRD_W-1:0]);
    else                       quo = $signed(q_r[CRD_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      prep_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      prep_r <= 1'b1;
    end else if (prep_r) begin
      prep_r <= 1'b0;
      run_r  <= 1'b1;
      cnt_r  <= 5'(CRD_W + 1);
    end else if (run_r) begin
      if (cnt_r == '0) run_r <= 1'b0;
      else             cnt_r <= cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      n_r   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      d_r   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      neg_r <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (prep_r) begin
      rem_r <= RW'(n_r) + RW'(d_r >> 1);
      dsh_r <= RW'(d_r) << CRD_W;
      q_r   <= '0;
    end else if (run_r && cnt_r != '0) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[CRD_W-1:0], 1'b1};
      end else begin
        q_r   <= {q_r[CRD_W-1:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

@@ sv/pmj_dp.sv @@
// datapath: point state, shared multiplier and accumulator, sqrt and divider units,
// vertex assembly and output register; depends on pmj_pkg, pmj_sqrt, pmj_div
module pmj_dp import pmj_pkg::*; #(
  parameter int MAX_POINTS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [11:0]        cfg_wr_data,
  input  logic               in_take,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic               in_new,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [63:0]        out_tdata,
  output logic               out_tlast
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [11:0]             thick_r;
  logic [CW-1:0]           cnt_r;
  logic signed [15:0]      px_r, py_r, nx_r, ny_r;
  logic signed [16:0]      ax_r, ay_r, bx, by;
  logic signed [15:0]      h;
  logic signed [25:0]      ma;
  logic signed [22:0]      mb;
  logic signed [48:0]      prod_nxt;
  logic signed [47:0]      prod_r;
  logic signed [NUM_W-1:0] acc_r, p8;
  logic signed [34:0]      cross_r;
  logic [ROOT_W-1:0]       la_r, lb_r, sq_root;
  logic signed [CRD_W-1:0] ox_r, oy_r, mx_r, my_r, div_q;
  logic signed [NUM_W-1:0] div_num;
  logic signed [DEN_W-1:0] div_den;
  logic                    sq_done, div_done;
  logic                    out_vld_r, out_last_r;
  logic [63:0]             out_data_r;

  assign h  = {1'b0, thick_r, 3'b000};
  assign bx = {px_r[15], px_r} - {nx_r[15], nx_r};
  assign by = {py_r[15], py_r} - {ny_r[15], ny_r};

  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.cnt_one    = (cnt_r == CW'(1));
  assign stat.full       = (cnt_r == CW'(MAX_POINTS));
  assign stat.dup        = (cnt_r != '0) && (px_r == nx_r) && (py_r == ny_r);
  assign stat.cross_zero = (cross_r == '0);
  assign stat.sq_done    = sq_done;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_vld_r || out_tready;

  // multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_sel)
      MS_BB_X:  begin ma = 26'(bx);   mb = 23'(bx); end
      MS_BB_Y:  begin ma = 26'(by);   mb = 23'(by); end
      MS_AA_X:  begin ma = 26'(ax_r); mb = 23'(ax_r); end
      MS_AA_Y:  begin ma = 26'(ay_r); mb = 23'(ay_r); end
      MS_H_B:   begin ma = 26'(h);    mb = cmd.axis ? 23'(bx) : 23'(by); end
      MS_AX_BY: begin ma = 26'(ax_r); mb = 23'(by); end
      MS_AY_BX: begin ma = 26'(ay_r); mb = 23'(bx); end
      MS_LA_B:  begin ma = $signed({1'b0, la_r}); mb = cmd.axis ? 23'(by) : 23'(bx); end
      MS_A_LB:  begin ma = $signed({1'b0, lb_r}); mb = cmd.axis ? 23'(ay_r) : 23'(ax_r); end
      MS_H_DHI: begin ma = 26'($signed(acc_r[43:22])); mb = 23'(h); end
      MS_H_DLO: begin ma = 26'(h); mb = $signed({1'b0, acc_r[21:0]}); end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  assign prod_nxt = ma * mb;
  assign p8       = NUM_W'(prod_r) <<< 8;

  // divider operands: perpendicular offset or miter
  always_comb begin
    unique case (cmd.div_src)
      DS_PROD: begin
        div_num = cmd.axis ? p8 : -p8;
        div_den = DEN_W'($signed({1'b0, lb_r}));
      end
      DS_ACC: begin
        div_num = acc_r;
        div_den = DEN_W'(cross_r) <<< 8;
      end
      default: begin
        div_num = acc_r;
        div_den = DEN_W'(cross_r) <<< 8;
      end
    endcase
  end

  pmj_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.sq_go),
    .din   ({acc_r[33:0], 16'b0}),
    .done  (sq_done),
    .root  (sq_root)
  );

  pmj_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  // control state: config register and point count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r <= 12'd16;
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) thick_r <= cfg_wr_data;
      if (in_take && in_new)          cnt_r <= '0;
      else if (cmd.save == SV_COMMIT) cnt_r <= cnt_r + CW'(1);
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt[47:0];
    unique case (cmd.acc_op)
      AC_HOLD: acc_r <= acc_r;
      AC_LOAD: acc_r <= NUM_W'(prod_r);
      AC_ADD:  acc_r <= acc_r + NUM_W'(prod_r);
      AC_SUB:  acc_r <= acc_r - NUM_W'(prod_r);
      AC_HI:   acc_r <= NUM_W'(prod_r) <<< 22;
      default: acc_r <= acc_r;
    endcase
    if (in_take) begin
      px_r <= in_x;
      py_r <= in_y;
    end
    unique case (cmd.save)
      SV_NONE:  ;
      SV_LB:    lb_r <= sq_root;
      SV_LA:    la_r <= sq_root;
      SV_OFF:   if (cmd.axis) oy_r <= div_q; else ox_r <= div_q;
      SV_MIT:   if (cmd.axis) my_r <= div_q; else mx_r <= div_q;
      SV_CROSS: cross_r <= acc_r[34:0];
      SV_FIRST: begin
        ox_r <= '0;
        oy_r <= CRD_W'(h);
      end
      SV_COMMIT: begin
        nx_r <= px_r;
        ny_r <= py_r;
        ax_r <= stat.cnt_zero ? '0 : bx;
        ay_r <= stat.cnt_zero ? '0 : by;
      end
      default: ;
    endcase
  end

  // vertex assembly
  logic                    em_old, em_plus;
  logic signed [15:0]      vpx, vpy;
  logic signed [CRD_W-1:0] vox, voy;
  logic signed [CRD_W:0]   sx, sy;
  logic [12:0]             slot_new, slot;
  logic [CRD_W-1:0]        vx, vy;

  assign em_old   = (cmd.emit == EM_OLD_M) || (cmd.emit == EM_OLD_P);
  assign em_plus  = (cmd.emit == EM_OLD_P) || (cmd.emit == EM_NEW_P);
  assign vpx      = em_old ? nx_r : px_r;
  assign vpy      = em_old ? ny_r : py_r;
  assign vox      = (em_old && !stat.cnt_one) ? mx_r : ox_r;
  assign voy      = (em_old && !stat.cnt_one) ? my_r : oy_r;
  assign sx       = em_plus ? $signed({vpx[15], vpx, 8'b0}) + (CRD_W+1)'(vox)
                            : $signed({vpx[15], vpx, 8'b0}) - (CRD_W+1)'(vox);
  assign sy       = em_plus ? $signed({vpy[15], vpy, 8'b0}) + (CRD_W+1)'(voy)
                            : $signed({vpy[15], vpy, 8'b0}) - (CRD_W+1)'(voy);
  assign vx       = (sx[CRD_W] != sx[CRD_W-1]) ? {sx[CRD_W], {(CRD_W-1){!sx[CRD_W]}}}
                                                 : sx[CRD_W-1:0];
  assign vy       = (sy[CRD_W] != sy[CRD_W-1]) ? {sy[CRD_W], {(CRD_W-1){!sy[CRD_W]}}}
                                                 : sy[CRD_W-1:0];
  assign slot_new = 13'({cnt_r, 1'b0});
  assign slot     = em_old ? (slot_new - 13'd2) : slot_new;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      out_data_r <= {3'b000, vy, vx, slot[12:1], em_plus};
      out_last_r <= (cmd.emit == EM_NEW_P);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ sv/pmj_ctrl.sv @@
// controller: sequences the micro-steps of one point through the datapath
// depends on pmj_pkg
module pmj_ctrl import pmj_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK: begin
        priority if (stat.dup || stat.full) state_nxt = S_IDLE;
        else if (stat.cnt_zero)             state_nxt = S_EM_NM;
        else                                state_nxt = S_SQ1;
      end
      S_SQ1:    state_nxt = S_SQ2;
      S_SQ2:    state_nxt = S_SQ3;
      S_SQ3:    state_nxt = S_SQB_GO;
      S_SQB_GO: state_nxt = S_SQB_W;
      S_SQB_W:  if (stat.sq_done) state_nxt = S_PERP_M;
      S_PERP_M: state_nxt = S_PERP_D;
      S_PERP_D: state_nxt = S_PERP_W;
      S_PERP_W: begin
        if (stat.div_done) begin
          if (!axis_r) begin
            axis_nxt  = 1'b1;
            state_nxt = S_PERP_M;
          end else begin
            axis_nxt  = 1'b0;
            state_nxt = stat.cnt_one ? S_EM_OM : S_CR1;
          end
        end
      end
      S_CR1:    state_nxt = S_CR2;
      S_CR2:    state_nxt = S_CR3;
      S_CR3:    state_nxt = S_CR4;
      S_CR4:    state_nxt = S_CR5;
      S_CR5:    state_nxt = stat.cross_zero ? S_EM_NM : S_SA;
      S_SA:     state_nxt = S_SQA_GO;
      S_SQA_GO: state_nxt = S_SQA_W;
      S_SQA_W:  if (stat.sq_done) state_nxt = S_MI1;
      S_MI1:    state_nxt = S_MI2;
      S_MI2:    state_nxt = S_MI3;
      S_MI3:    state_nxt = S_MI4;
      S_MI4:    state_nxt = S_MI5;
      S_MI5:    state_nxt = S_MI6;
      S_MI6:    state_nxt = S_MI_D;
      S_MI_D:   state_nxt = S_MI_W;
      S_MI_W: begin
        if (stat.div_done) begin
          if (!axis_r) begin
            axis_nxt  = 1'b1;
            state_nxt = S_MI1;
          end else begin
            axis_nxt  = 1'b0;
            state_nxt = S_EM_OM;
          end
        end
      end
      S_EM_OM:  if (stat.out_free) state_nxt = S_EM_OP;
      S_EM_OP:  if (stat.out_free) state_nxt = S_EM_NM;
      S_EM_NM:  if (stat.out_free) state_nxt = S_EM_NP;
      S_EM_NP:  if (stat.out_free) state_nxt = S_UPD;
      S_UPD:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = axis_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE:   ;
      S_CHECK:  if (stat.cnt_zero) cmd.save = SV_FIRST;
      S_SQ1:    cmd.mul_sel = MS_BB_X;
      S_SQ2:    begin cmd.mul_sel = MS_BB_Y; cmd.acc_op = AC_LOAD; end
      S_SQ3:    cmd.acc_op = AC_ADD;
      S_SQB_GO: cmd.sq_go = 1'b1;
      S_SQB_W:  if (stat.sq_done) cmd.save = SV_LB;
      S_PERP_M: cmd.mul_sel = MS_H_B;
      S_PERP_D: begin cmd.div_go = 1'b1; cmd.div_src = DS_PROD; end
      S_PERP_W: if (stat.div_done) cmd.save = SV_OFF;
      S_CR1:    cmd.mul_sel = MS_AX_BY;
      S_CR2:    begin cmd.mul_sel = MS_AY_BX; cmd.acc_op = AC_LOAD; end
      S_CR3:    cmd.acc_op = AC_SUB;
      S_CR4:    begin cmd.save = SV_CROSS; cmd.mul_sel = MS_AA_X; end
      S_CR5:    begin cmd.mul_sel = MS_AA_Y; cmd.acc_op = AC_LOAD; end
      S_SA:     cmd.acc_op = AC_ADD;
      S_SQA_GO: cmd.sq_go = 1'b1;
      S_SQA_W:  if (stat.sq_done) cmd.save = SV_LA;
      S_MI1:    cmd.mul_sel = MS_LA_B;
      S_MI2:    begin cmd.mul_sel = MS_A_LB; cmd.acc_op = AC_LOAD; end
      S_MI3:    cmd.acc_op = AC_SUB;
      S_MI4:    cmd.mul_sel = MS_H_DHI;
      S_MI5:    begin cmd.mul_sel = MS_H_DLO; cmd.acc_op = AC_HI; end
      S_MI6:    cmd.acc_op = AC_ADD;
      S_MI_D:   begin cmd.div_go = 1'b1; cmd.div_src = DS_ACC; end
      S_MI_W:   if (stat.div_done) cmd.save = SV_MIT;
      S_EM_OM:  if (stat.out_free) cmd.emit = EM_OLD_M;
      S_EM_OP:  if (stat.out_free) cmd.emit = EM_OLD_P;
      S_EM_NM:  if (stat.out_free) cmd.emit = EM_NEW_M;
      S_EM_NP:  if (stat.out_free) cmd.emit = EM_NEW_P;
      S_UPD:    cmd.save = SV_COMMIT;
      default:  ;
    endcase
  end

endmodule

@@ sv/pmj_chk.sv @@
// port-level checker for polyline_miter_join, attached by bind
// depends only on the top level's ports
module pmj_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [11:0] cfg_wr_data,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // one point at a time
  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second point taken while busy");

  // more vertices of the same point still to come
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("input ready before last vertex");

  // the last vertex is always a plus vertex in an odd slot
  a_last_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[0])
    else $error("last vertex in even slot");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind polyline_miter_join pmj_chk u_pmj_chk (.*);
